/* src/sha_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sha_pkg: shared types and constants
// Round constants, initial hash and sequencer state codes.
// ----------------------------------------------------------------------------
package sha_pkg;

    typedef enum logic [5:0] {
        ST_IDLE  = 6'b000001,
        ST_PAD   = 6'b000010,
        ST_LOAD  = 6'b000100,
        ST_ROUND = 6'b001000,
        ST_ADD   = 6'b010000,
        ST_OUT   = 6'b100000
    } state_t;

    typedef struct packed {
        logic        start;
        logic        step;
        logic [5:0]  rnd;
    } rnd_ctl_t;

    localparam logic [7:0] PAD_BYTE = 8'h80;
    localparam logic [5:0] LEN_OFFSET = 6'd56;

    localparam logic [255:0] INIT_HASH = {
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    function automatic logic [31:0] round_k(input logic [5:0] r);
        logic [31:0] k;
        case (r)
            6'd0: k = 32'h428a2f98;  6'd1: k = 32'h71374491;
            6'd2: k = 32'hb5c0fbcf;  6'd3: k = 32'he9b5dba5;
            6'd4: k = 32'h3956c25b;  6'd5: k = 32'h59f111f1;
            6'd6: k = 32'h923f82a4;  6'd7: k = 32'hab1c5ed5;
            6'd8: k = 32'hd807aa98;  6'd9: k = 32'h12835b01;
            6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
            6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe;
            6'd14: k = 32'h9bdc06a7; 6'd15: k = 32'hc19bf174;
            6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
            6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc;
            6'd20: k = 32'h2de92c6f; 6'd21: k = 32'h4a7484aa;
            6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
            6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d;
            6'd26: k = 32'hb00327c8; 6'd27: k = 32'hbf597fc7;
            6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
            6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967;
            6'd32: k = 32'h27b70a85; 6'd33: k = 32'h2e1b2138;
            6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
            6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb;
            6'd38: k = 32'h81c2c92e; 6'd39: k = 32'h92722c85;
            6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
            6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3;
            6'd44: k = 32'hd192e819; 6'd45: k = 32'hd6990624;
            6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
            6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08;
            6'd50: k = 32'h2748774c; 6'd51: k = 32'h34b0bcb5;
            6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
            6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3;
            6'd56: k = 32'h748f82ee; 6'd57: k = 32'h78a5636f;
            6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
            6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb;
            6'd62: k = 32'hbef9a3f7; 6'd63: k = 32'hc67178f2;
            default: k = 32'h0;
        endcase
        return k;
    endfunction

endpackage
`default_nettype wire

/* src/sha_stream_if.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sha_in_if / sha_out_if: valid/ready channels
// Input byte channel and digest word channel.
// ----------------------------------------------------------------------------
interface sha_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       byte_present;
    logic       is_last;
    modport source (output valid, data_byte, byte_present, is_last, input ready);
    modport sink (input valid, data_byte, byte_present, is_last, output ready);
endinterface

interface sha_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;
    modport source (output valid, digest_word, word_index, last_word, input ready);
    modport sink (input valid, digest_word, word_index, last_word, output ready);
endinterface
`default_nettype wire

/* src/sha_round.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sha_round: shared compression round unit
// Holds working vars and the 16-word schedule window; one round per step.
// ----------------------------------------------------------------------------
module sha_round (
    input  wire logic             clk,
    input  wire sha_pkg::rnd_ctl_t ctl,
    input  wire logic [511:0]     block,
    input  wire logic [255:0]     hash_in,
    output logic      [255:0]     vars
);

    logic [31:0] v_reg [8];
    logic [31:0] w_reg [16];
    logic [31:0] wr, s1, ch, s0, mj, t1, t2, g0, g1;

    function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
        return (x >> n) | (x << (32 - n));
    endfunction

    always_comb
    begin
        g0 = rotr(w_reg[1], 7) ^ rotr(w_reg[1], 18) ^ (w_reg[1] >> 3);
        g1 = rotr(w_reg[14], 17) ^ rotr(w_reg[14], 19) ^ (w_reg[14] >> 10);
        // window keeps w[r] at slot 0; beyond round 15 it is computed
        wr = (ctl.rnd < 6'd16) ? w_reg[0] : (w_reg[0] + g0 + w_reg[9] + g1);
        s1 = rotr(v_reg[4], 6) ^ rotr(v_reg[4], 11) ^ rotr(v_reg[4], 25);
        ch = (v_reg[4] & v_reg[5]) ^ (~v_reg[4] & v_reg[6]);
        s0 = rotr(v_reg[0], 2) ^ rotr(v_reg[0], 13) ^ rotr(v_reg[0], 22);
        mj = (v_reg[0] & v_reg[1]) ^ (v_reg[0] & v_reg[2]) ^ (v_reg[1] & v_reg[2]);
        t1 = v_reg[7] + s1 + ch + sha_pkg::round_k(ctl.rnd) + wr;
        t2 = s0 + mj;
    end

    always_ff @(posedge clk)
    begin
        if (ctl.start)
        begin
            for (int i = 0; i < 8; i++)
                v_reg[i] <= hash_in[255 - 32*i -: 32];
            for (int i = 0; i < 16; i++)
                w_reg[i] <= block[511 - 32*i -: 32];
        end
        else if (ctl.step)
        begin
            v_reg[7] <= v_reg[6];
            v_reg[6] <= v_reg[5];
            v_reg[5] <= v_reg[4];
            v_reg[4] <= v_reg[3] + t1;
            v_reg[3] <= v_reg[2];
            v_reg[2] <= v_reg[1];
            v_reg[1] <= v_reg[0];
            v_reg[0] <= t1 + t2;
            for (int i = 0; i < 15; i++)
                w_reg[i] <= w_reg[i+1];
            w_reg[15] <= wr;
        end
    end

    always_comb
    begin
        for (int i = 0; i < 8; i++)
            vars[255 - 32*i -: 32] = v_reg[i];
    end

endmodule
`default_nettype wire

/* src/sha256_stream_hasher_unit.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sha256_stream_hasher_unit: SHA-256 over a byte stream
// At most one byte per input transfer; eight digest words out per message.
// ----------------------------------------------------------------------------
// Usage:
//   in  : valid/ready transfer of {data_byte, byte_present, is_last}.
//   out : eight transfers of {digest_word, word_index, last_word}, word 0
//         first, last_word set on word 7.
// A byte that neither fills the block nor ends the message leaves ready high,
// so such transfers can follow back to back. A byte that fills the block
// holds ready low through load, 64 rounds on the single shared round unit,
// and the hash add. On is_last the padding bytes are written one per cycle
// into the block, each full block is compressed (one or two blocks), then
// the digest is presented one word per accepted out transfer.
// Throughput is bounded by the round unit: no byte is taken while a block
// is being compressed.
// Reset puts the initial hash in place and clears counters; the block buffer
// holds no reset value. When the receiver stalls the current digest word
// holds and no input is taken until all eight words are gone.
// ----------------------------------------------------------------------------
module sha256_stream_hasher_unit (
    input  wire logic  clk,
    input  wire logic  rst_n,
    sha_in_if.sink     in_ch,
    sha_out_if.source  out_ch
);

    sha_pkg::state_t   state_reg, state_next;
    logic [511:0]      buf_reg;       // bytes shift in at the bottom
    logic [5:0]        fill_reg;
    logic [60:0]       count_reg;
    logic [255:0]      hash_reg;
    logic [5:0]        rnd_reg;
    logic              final_reg;     // padding pass in progress
    logic              lenphase_reg;  // writing the length bytes
    logic [2:0]        lenidx_reg;
    logic [2:0]        widx_reg;
    logic              pad_first_reg; // 0x80 still to be written
    logic              done_len_reg;
    logic              done_len;

    sha_pkg::rnd_ctl_t ctl;
    logic [511:0]      block;
    logic [255:0]      vars;
    logic [63:0]       bits;
    logic              wr_en;
    logic [7:0]        wr_byte;
    logic              in_fire;
    logic              out_fire;

    assign in_fire  = in_ch.valid & in_ch.ready;
    assign out_fire = out_ch.valid & out_ch.ready;
    assign in_ch.ready = (state_reg == sha_pkg::ST_IDLE);
    assign bits = {count_reg, 3'b000};
    assign done_len = done_len_reg;

    // after 64 writes the first byte of the block sits at the top
    assign block = buf_reg;

    // one byte written per cycle, from input or from the padding sequencer
    always_comb
    begin
        wr_en = 1'b0;
        wr_byte = in_ch.data_byte;
        if (in_fire && in_ch.byte_present)
            wr_en = 1'b1;
        else if (state_reg == sha_pkg::ST_PAD)
        begin
            wr_en = 1'b1;
            if (pad_first_reg)
                wr_byte = sha_pkg::PAD_BYTE;
            else if (lenphase_reg)
                wr_byte = bits[63 - 8*lenidx_reg -: 8];
            else
                wr_byte = 8'h00;
        end
    end

    assign ctl.start = (state_reg == sha_pkg::ST_LOAD);
    assign ctl.step  = (state_reg == sha_pkg::ST_ROUND);
    assign ctl.rnd   = rnd_reg;

    sha_round u_round (
        .clk     (clk),
        .ctl     (ctl),
        .block   (block),
        .hash_in (hash_reg),
        .vars    (vars)
    );

    always_ff @(posedge clk)
    begin
        if (wr_en)
            buf_reg <= {buf_reg[503:0], wr_byte};
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            sha_pkg::ST_IDLE:
                if (in_fire)
                begin
                    if (in_ch.byte_present && fill_reg == 6'd63)
                        state_next = sha_pkg::ST_LOAD;
                    else if (in_ch.is_last)
                        state_next = sha_pkg::ST_PAD;
                end
            sha_pkg::ST_PAD:
                if (fill_reg == 6'd63)
                    state_next = sha_pkg::ST_LOAD;
            sha_pkg::ST_LOAD:
                state_next = sha_pkg::ST_ROUND;
            sha_pkg::ST_ROUND:
                if (rnd_reg == 6'd63)
                    state_next = sha_pkg::ST_ADD;
            sha_pkg::ST_ADD:
                if (!final_reg)
                    state_next = sha_pkg::ST_IDLE;
                else if (lenphase_reg && lenidx_reg == 3'd0 && !pad_first_reg
                         && fill_reg == 6'd0 && done_len)
                    state_next = sha_pkg::ST_OUT;
                else
                    state_next = sha_pkg::ST_PAD;
            sha_pkg::ST_OUT:
                if (out_fire && widx_reg == 3'd7)
                    state_next = sha_pkg::ST_IDLE;
            default:
                state_next = sha_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= sha_pkg::ST_IDLE;
            fill_reg      <= 6'd0;
            count_reg     <= 61'd0;
            hash_reg      <= sha_pkg::INIT_HASH;
            rnd_reg       <= 6'd0;
            final_reg     <= 1'b0;
            lenphase_reg  <= 1'b0;
            lenidx_reg    <= 3'd0;
            widx_reg      <= 3'd0;
            pad_first_reg <= 1'b0;
            done_len_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (wr_en)
                fill_reg <= fill_reg + 6'd1;
            if (in_fire)
            begin
                if (in_ch.byte_present)
                    count_reg <= count_reg + 61'd1;
                if (in_ch.is_last)
                begin
                    final_reg     <= 1'b1;
                    pad_first_reg <= 1'b1;
                    lenphase_reg  <= 1'b0;
                    lenidx_reg    <= 3'd0;
                    done_len_reg  <= 1'b0;
                end
            end
            if (state_reg == sha_pkg::ST_PAD)
            begin
                pad_first_reg <= 1'b0;
                if (lenphase_reg)
                begin
                    lenidx_reg <= lenidx_reg + 3'd1;
                    if (lenidx_reg == 3'd7)
                        done_len_reg <= 1'b1;
                end
                else if (fill_reg + 6'd1 == sha_pkg::LEN_OFFSET)
                    lenphase_reg <= 1'b1;
            end
            if (state_reg == sha_pkg::ST_LOAD)
                rnd_reg <= 6'd0;
            else if (state_reg == sha_pkg::ST_ROUND)
                rnd_reg <= rnd_reg + 6'd1;
            if (state_reg == sha_pkg::ST_ADD)
            begin
                for (int i = 0; i < 8; i++)
                    hash_reg[255 - 32*i -: 32] <= hash_reg[255 - 32*i -: 32]
                                                  + vars[255 - 32*i -: 32];
            end
            if (state_reg == sha_pkg::ST_OUT && out_fire)
            begin
                widx_reg <= widx_reg + 3'd1;
                if (widx_reg == 3'd7)
                begin
                    hash_reg  <= sha_pkg::INIT_HASH;
                    count_reg <= 61'd0;
                    final_reg <= 1'b0;
                    fill_reg  <= 6'd0;
                end
            end
        end
    end

    assign out_ch.valid       = (state_reg == sha_pkg::ST_OUT);
    assign out_ch.digest_word = hash_reg[255 - 32*widx_reg -: 32];
    assign out_ch.word_index  = widx_reg;
    assign out_ch.last_word   = (widx_reg == 3'd7);

    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(in_ch.ready && out_ch.valid))
        else $error("input taken while digest pending");
    a_round_count: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == sha_pkg::ST_LOAD) |=> (state_reg == sha_pkg::ST_ROUND && rnd_reg == 6'd0))
        else $error("round counter not restarted");
    a_out_at_block_edge: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_ch.valid) |-> (fill_reg == 6'd0 && widx_reg == 3'd0))
        else $error("digest out of block alignment");

endmodule
`default_nettype wire

/* dv/sha256_stream_hasher_unit_tb_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb channel notes
// Channel interfaces come from the RTL source; this file adds only the item types.
// ----------------------------------------------------------------------------
package sha_tb_pkg;

    typedef struct {
        logic [7:0] data_byte;
        logic       byte_present;
        logic       is_last;
    } byte_item_t;

    typedef struct {
        logic [31:0] digest_word;
        logic [2:0]  word_index;
        logic        last_word;
    } digest_item_t;

endpackage

/* dv/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: SHA-256 byte stream hasher check
// Feeds byte transfers with random gaps, predicts the eight digest words of
// each message with an in-bench SHA-256, and compares every digest transfer.
// ----------------------------------------------------------------------------
module testbench;

    logic clk;
    logic rst_n;

    sha_in_if  in_ch ();
    sha_out_if out_ch ();

    sha256_stream_hasher_unit DUT (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch)
    );

    // SHA-256 constants for the predictor
    logic [31:0] k_tab [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };
    logic [31:0] iv_tab [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    // predictor state
    logic [31:0] chain [8];
    logic [7:0]  blk [64];
    int          fill;
    logic [60:0] msg_len;

    sha_tb_pkg::byte_item_t   pending_bytes [$];
    sha_tb_pkg::digest_item_t digest_expect [$];
    int           errors;
    bit           hold_for_drain;
    bit           quiet_gaps;

    initial clk = 1'b0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
        return (x >> n) | (x << (32 - n));
    endfunction

    // one 64-round compression of blk into chain
    task automatic compress();
        logic [31:0] w [64];
        logic [31:0] a, b, c, d, e, f, g, h, t1, t2;
        for (int i = 0; i < 16; i++)
            w[i] = {blk[4*i], blk[4*i+1], blk[4*i+2], blk[4*i+3]};
        for (int i = 16; i < 64; i++)
            w[i] = w[i-16] + (rotr(w[i-15], 7) ^ rotr(w[i-15], 18) ^ (w[i-15] >> 3))
                 + w[i-7] + (rotr(w[i-2], 17) ^ rotr(w[i-2], 19) ^ (w[i-2] >> 10));
        a = chain[0]; b = chain[1]; c = chain[2]; d = chain[3];
        e = chain[4]; f = chain[5]; g = chain[6]; h = chain[7];
        for (int r = 0; r < 64; r++)
        begin
            t1 = h + (rotr(e, 6) ^ rotr(e, 11) ^ rotr(e, 25)) + ((e & f) ^ (~e & g))
               + k_tab[r] + w[r];
            t2 = (rotr(a, 2) ^ rotr(a, 13) ^ rotr(a, 22)) ^ 32'h0;
            t2 = t2 + ((a & b) ^ (a & c) ^ (b & c));
            h = g; g = f; f = e; e = d + t1;
            d = c; c = b; b = a; a = t1 + t2;
        end
        chain[0] += a; chain[1] += b; chain[2] += c; chain[3] += d;
        chain[4] += e; chain[5] += f; chain[6] += g; chain[7] += h;
    endtask

    task automatic append_byte(input logic [7:0] v);
        blk[fill] = v;
        fill++;
        if (fill == 64)
        begin
            compress();
            fill = 0;
        end
    endtask

    // advance the hash by one accepted transfer; queue digest on end of message
    task automatic hash_step(input sha_tb_pkg::byte_item_t it);
        logic [63:0]  bit_len;
        sha_tb_pkg::digest_item_t d;
        if (it.byte_present)
        begin
            append_byte(it.data_byte);
            msg_len = msg_len + 61'd1;
        end
        if (it.is_last)
        begin
            bit_len = {msg_len, 3'b000};
            append_byte(8'h80);
            while (fill != 56)
                append_byte(8'h00);
            for (int i = 0; i < 8; i++)
                append_byte(bit_len[63 - 8*i -: 8]);
            for (int i = 0; i < 8; i++)
            begin
                d.digest_word = chain[i];
                d.word_index = 3'(i);
                d.last_word = (i == 7);
                digest_expect.push_back(d);
            end
            chain = iv_tab;
            fill = 0;
            msg_len = '0;
        end
    endtask

    task automatic report(input string what, input logic [31:0] got,
                          input logic [31:0] want);
        $display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
        errors++;
    endtask

    task automatic add_byte(input logic [7:0] v, input bit p, input bit l);
        sha_tb_pkg::byte_item_t it;
        it.data_byte = v;
        it.byte_present = p;
        it.is_last = l;
        pending_bytes.push_back(it);
    endtask

    // a whole message of n random bytes, ending either on a byte or on a
    // bare end marker; idle transfers sprinkled in now and then
    task automatic add_message(input int n, input bit bare_end);
        for (int i = 0; i < n; i++)
        begin
            if ($urandom_range(0, 19) == 0)
                add_byte(8'($urandom), 1'b0, 1'b0);
            add_byte(8'($urandom), 1'b1, !bare_end && (i == n - 1));
        end
        if (bare_end || n == 0)
            add_byte(8'($urandom), 1'b0, 1'b1);
    endtask

    // driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_ch.valid <= 1'b0;
            in_ch.data_byte <= '0;
            in_ch.byte_present <= 1'b0;
            in_ch.is_last <= 1'b0;
        end
        else
        begin
            if (in_ch.valid && in_ch.ready)
            begin
                hash_step(pending_bytes.pop_front());
            end
            if ((in_ch.valid && !in_ch.ready))
            begin
                // hold the current transfer
            end
            else if (pending_bytes.size() != 0 && !hold_for_drain
                     && (quiet_gaps || $urandom_range(0, 99) >= 6))
            begin
                in_ch.valid <= 1'b1;
                in_ch.data_byte <= pending_bytes[0].data_byte;
                in_ch.byte_present <= pending_bytes[0].byte_present;
                in_ch.is_last <= pending_bytes[0].is_last;
            end
            else
                in_ch.valid <= 1'b0;
        end
    end

    // monitor and output stalls
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_ch.ready <= 1'b0;
        else
        begin
            if (out_ch.valid && out_ch.ready)
            begin
                if (digest_expect.size() == 0)
                begin
                    report("unexpected digest transfer", out_ch.digest_word, 32'h0);
                end
                else
                begin
                    sha_tb_pkg::digest_item_t e;
                    e = digest_expect.pop_front();
                    if (out_ch.digest_word !== e.digest_word)
                        report("digest_word", out_ch.digest_word, e.digest_word);
                    if (out_ch.word_index !== e.word_index)
                        report("word_index", 32'(out_ch.word_index), 32'(e.word_index));
                    if (out_ch.last_word !== e.last_word)
                        report("last_word", 32'(out_ch.last_word), 32'(e.last_word));
                end
            end
            out_ch.ready <= quiet_gaps || ($urandom_range(0, 99) >= 6);
        end
    end

    // stimulus
    initial begin
        int n_queued;
        errors = 0;
        hold_for_drain = 0;
        quiet_gaps = 0;
        chain = iv_tab;
        fill = 0;
        msg_len = '0;
        foreach (blk[i])
            blk[i] = 8'h00;
        rst_n = 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // directed: empty message, idle transfer, extreme bytes,
        // byte together with end, "abc"
        add_byte(8'hff, 1'b0, 1'b1);
        add_byte(8'h5a, 1'b0, 1'b0);
        add_byte(8'h00, 1'b1, 1'b0);
        add_byte(8'hff, 1'b1, 1'b1);
        add_byte(8'h61, 1'b1, 1'b0);
        add_byte(8'h62, 1'b1, 1'b0);
        add_byte(8'h63, 1'b1, 1'b1);
        add_byte(8'h00, 1'b0, 1'b1);
        wait (pending_bytes.size() == 0 && digest_expect.size() == 0);

        // padding boundaries: 55 and 56 bytes (one vs two pad blocks),
        // 64 bytes (full block before the end marker)
        add_message(55, 0);
        add_message(56, 1);
        add_message(64, 1);
        // hold the sender until every digest word has drained
        wait (pending_bytes.size() == 0);
        hold_for_drain = 1;
        wait (digest_expect.size() == 0);
        hold_for_drain = 0;

        // random messages; stretch with no gaps in the middle
        n_queued = 0;
        while (n_queued < 130)
        begin
            int n;
            n = ($urandom_range(0, 9) == 0) ? $urandom_range(56, 130)
                                             : $urandom_range(0, 20);
            if (n_queued > 30 && n_queued < 90)
                quiet_gaps = 1;
            else if (n_queued >= 90)
                quiet_gaps = 0;
            add_message(n, $urandom_range(0, 1));
            n_queued += n + 1;
            wait (pending_bytes.size() < 40);
        end
        quiet_gaps = 0;

        wait (pending_bytes.size() == 0 && digest_expect.size() == 0);
        repeat (200) @(posedge clk);
        if (errors == 0)
            $display("testbench: clean");
        else
            $display("testbench: errors");
        $finish;
    end

    initial begin
        #5ms;
        $display("testbench: errors");
        $finish;
    end

endmodule
